>>> hdl/bdascii_pkg.sv
// Shared constants, command and status types for the binary to decimal ASCII converter.
`default_nettype none

package bdascii_pkg;

   // Default configuration of the converter.
   localparam int MAX_DIGITS_DEF = 20;
   localparam int VALUE_BITS_DEF = 64;

   // Fixed field widths of the request and response beats.
   localparam int IN_VALUE_W = 64;
   localparam int LIMIT_W    = 8;
   localparam int PAD_W      = 5;
   localparam int CHAR_W     = 6;
   localparam int MODE_W     = 2;

   // Character constants.
   localparam logic [LIMIT_W-1:0] NO_LIMIT   = 8'd255;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'h30;

   // Value width modes; the unused code behaves as the 64-bit mode.
   localparam logic [MODE_W-1:0] MODE_16    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_32    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_64    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture a request beat and clear the BCD digits
      logic step;   // one shift-and-add-3 iteration
      logic size;   // work out the output length and character count
      logic emit;   // load the next character into the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic conv_last;   // the current step is the final conversion bit
      logic no_chars;    // the sizing result is an empty character run
      logic emit_last;   // the next character is the final one
      logic out_free;    // the response register can take a character
   } status_type;

endpackage

`default_nettype wire

>>> hdl/bdascii_ctrl.sv
// Controller state machine that sequences load, conversion, sizing and emission.
`default_nettype none

module bdascii_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  bdascii_pkg::status_type status,
   output bdascii_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SIZE    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            if (status.conv_last) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = status.no_chars ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/bdascii_dp.sv
// Datapath: width register, double dabble digits, sizing and the response register.
`default_nettype none

module bdascii_dp #(
   parameter int MAX_DIGITS = bdascii_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = bdascii_pkg::VALUE_BITS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_wr_en,
   input  wire [bdascii_pkg::MODE_W-1:0]          csr_wr_data,
   input  wire [bdascii_pkg::IN_VALUE_W-1:0]      req_value,
   input  wire [bdascii_pkg::LIMIT_W-1:0]         req_char_limit,
   input  wire [bdascii_pkg::PAD_W-1:0]           req_pad_width,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [bdascii_pkg::CHAR_W-1:0]         rsp_digit_char,
   output logic                                   rsp_last,
   output logic [bdascii_pkg::LIMIT_W-1:0]        rsp_remaining_limit,
   input  bdascii_pkg::cmd_type                   cmd,
   output bdascii_pkg::status_type                status
);

   localparam int DIG_W = $clog2(MAX_DIGITS);
   localparam int LEN_W = $clog2(MAX_DIGITS + 1);
   localparam int CNT_W = $clog2(VALUE_BITS);

   logic [bdascii_pkg::MODE_W-1:0]  mode_ff;
   logic [VALUE_BITS-1:0]           shift_ff;
   logic [CNT_W-1:0]                bit_cnt_ff;
   logic [3:0]                      bcd_ff [MAX_DIGITS];
   logic [3:0]                      bcd_in [MAX_DIGITS];
   logic                            ovf_ff;
   logic                            ovf_in;
   logic [bdascii_pkg::LIMIT_W-1:0] limit_ff;
   logic [LEN_W-1:0]                pad_ff;
   logic [LEN_W-1:0]                len_ff;
   logic [LEN_W-1:0]                count_ff;
   logic [LEN_W-1:0]                idx_ff;
   logic [bdascii_pkg::LIMIT_W-1:0] remain_ff;
   logic [bdascii_pkg::LIMIT_W-1:0] remain_in;
   logic                            rsp_valid_ff;
   logic [bdascii_pkg::CHAR_W-1:0]  rsp_char_ff;
   logic                            rsp_last_ff;
   logic [bdascii_pkg::LIMIT_W-1:0] rsp_remain_ff;

   logic [bdascii_pkg::IN_VALUE_W-1:0] width_mask;
   logic [VALUE_BITS-1:0]              value_cut;
   logic [LEN_W-1:0]                   pad_sat;
   logic [LEN_W-1:0]                   ndig;
   logic [LEN_W-1:0]                   len_calc;
   logic [LEN_W-1:0]                   count_calc;
   logic [LEN_W-1:0]                   pos;
   logic [3:0]                         digit;
   logic                               emit_last;

   // Width mode selects how many low bits of the value take part.
   always_comb begin
      case (mode_ff)
         bdascii_pkg::MODE_16: width_mask = 64'h0000_0000_0000_FFFF;
         bdascii_pkg::MODE_32: width_mask = 64'h0000_0000_FFFF_FFFF;
         default:              width_mask = '1;
      endcase
      value_cut = VALUE_BITS'(req_value & width_mask);
      pad_sat   = (32'(req_pad_width) > MAX_DIGITS) ? LEN_W'(MAX_DIGITS)
                                                   : LEN_W'(req_pad_width);
   end

   // One shift-and-add-3 iteration: adjust every digit, then shift the
   // next value bit in at the units digit. A carry out of the top digit
   // marks a value with more digits than are kept.
   always_comb begin
      logic [3:0] adj [MAX_DIGITS];
      for (int d = 0; d < MAX_DIGITS; d++) begin
         adj[d] = (bcd_ff[d] >= 4'd5) ? bcd_ff[d] + 4'd3 : bcd_ff[d];
      end
      bcd_in[0] = {adj[0][2:0], shift_ff[VALUE_BITS-1]};
      for (int d = 1; d < MAX_DIGITS; d++) begin
         bcd_in[d] = {adj[d][2:0], adj[d-1][3]};
      end
      ovf_in = ovf_ff | adj[MAX_DIGITS-1][3];
   end

   // Significant digit count, padded length and number of characters.
   always_comb begin
      ndig = LEN_W'(1);
      for (int d = 1; d < MAX_DIGITS; d++) begin
         if (bcd_ff[d] != 4'd0) begin
            ndig = LEN_W'(d + 1);
         end
      end
      if (ovf_ff) begin
         ndig = LEN_W'(MAX_DIGITS);
      end
      len_calc = (ndig > pad_ff) ? ndig : pad_ff;
      if (limit_ff != bdascii_pkg::NO_LIMIT
          && 32'(limit_ff) < 32'(len_calc)) begin
         count_calc = LEN_W'(limit_ff);
      end else begin
         count_calc = len_calc;
      end
   end

   // Character selection, most significant position first.
   always_comb begin
      pos       = len_ff - LEN_W'(1) - idx_ff;
      digit     = bcd_ff[pos[DIG_W-1:0]];
      emit_last = (idx_ff + LEN_W'(1)) == count_ff;
      remain_in = (limit_ff == bdascii_pkg::NO_LIMIT) ? limit_ff
                                                      : remain_ff - 8'd1;
   end

   // Status toward the controller.
   always_comb begin
      status.conv_last = (bit_cnt_ff == CNT_W'(VALUE_BITS - 1));
      status.no_chars  = (limit_ff == '0);
      status.emit_last = emit_last;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Width mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bdascii_pkg::MODE_RESET;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Conversion and emission working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         shift_ff   <= value_cut;
         bit_cnt_ff <= '0;
         ovf_ff     <= 1'b0;
         limit_ff   <= req_char_limit;
         pad_ff     <= pad_sat;
         for (int d = 0; d < MAX_DIGITS; d++) begin
            bcd_ff[d] <= 4'd0;
         end
      end else if (cmd.step) begin
         shift_ff   <= shift_ff << 1;
         bit_cnt_ff <= bit_cnt_ff + CNT_W'(1);
         ovf_ff     <= ovf_in;
         bcd_ff     <= bcd_in;
      end
      if (cmd.size) begin
         len_ff    <= len_calc;
         count_ff  <= count_calc;
         idx_ff    <= '0;
         remain_ff <= limit_ff;
      end else if (cmd.emit) begin
         idx_ff    <= idx_ff + LEN_W'(1);
         remain_ff <= remain_in;
      end
   end

   // Response register: valid flag under reset, payload loaded per beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff   <= bdascii_pkg::ASCII_ZERO | {2'b00, digit};
         rsp_last_ff   <= emit_last;
         rsp_remain_ff <= remain_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_digit_char      = rsp_char_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_remaining_limit = rsp_remain_ff;

endmodule

`default_nettype wire

>>> hdl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
`default_nettype none

// Converts an unsigned value, cut to 16, 32 or 64 bits by the width mode
// register, into decimal ASCII characters sent most significant first, one
// per response beat, left padded with '0' up to pad_width (at most
// MAX_DIGITS) and cut after char_limit characters; a limit of 0 sends
// nothing and 255 means no limit. A request is loaded when it is accepted,
// converted by shift-and-add-3 steps at one value bit per cycle and sized,
// and its characters then go out one per cycle while the response side
// keeps up. The request side is ready again as soon as the final character
// sits in the response register.
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = bdascii_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = bdascii_pkg::VALUE_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire [bdascii_pkg::MODE_W-1:0]       csr_wr_data,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire [bdascii_pkg::IN_VALUE_W-1:0]   req_value,
   input  wire [bdascii_pkg::LIMIT_W-1:0]      req_char_limit,
   input  wire [bdascii_pkg::PAD_W-1:0]        req_pad_width,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [bdascii_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic                                rsp_last,
   output logic [bdascii_pkg::LIMIT_W-1:0]     rsp_remaining_limit
);

   bdascii_pkg::cmd_type    cmd;
   bdascii_pkg::status_type status;

   // Sequencer.
   bdascii_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Conversion datapath and response register.
   bdascii_dp #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_value           (req_value),
      .req_char_limit      (req_char_limit),
      .req_pad_width       (req_pad_width),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_digit_char      (rsp_digit_char),
      .rsp_last            (rsp_last),
      .rsp_remaining_limit (rsp_remaining_limit),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

`default_nettype wire

>>> bench/binary_to_decimal_ascii_tb.sv
// Self-checking testbench for the binary to decimal ASCII converter, with a character scoreboard.
module binary_to_decimal_ascii_tb;

   // The fourth width code is unused and must behave as the 64-bit mode.
   localparam logic [bdascii_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 12;
   // Room for the load, the 64 conversion steps, the sizing and some slack.
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DEC_SLOTS     = 20;

   typedef enum int {RSP_ALWAYS, RSP_RANDOM, RSP_PERIODIC} rsp_style_type;

   // One expected response beat.
   typedef struct {
      logic [bdascii_pkg::CHAR_W-1:0]  digit;
      logic                            last;
      logic [bdascii_pkg::LIMIT_W-1:0] remaining;
   } char_beat_type;

   // Holds the expected characters and the width mode the converter is set to.
   class DigitScoreboard;
      char_beat_type                    expected_chars[$];
      logic [bdascii_pkg::MODE_W-1:0]   width_mode;
      int                               mismatches;
      int                               requests_noted;
      int                               chars_checked;

      function new();
         width_mode = bdascii_pkg::MODE_RESET;
         mismatches = 0;
         requests_noted = 0;
         chars_checked = 0;
      endfunction

      function void set_width_mode(logic [bdascii_pkg::MODE_W-1:0] mode);
         width_mode = mode;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // Works out the characters that one accepted request beat must produce.
      function void note_request(logic [bdascii_pkg::IN_VALUE_W-1:0] value,
                                 logic [bdascii_pkg::LIMIT_W-1:0] lim,
                                 logic [bdascii_pkg::PAD_W-1:0] pad);
         logic [bdascii_pkg::IN_VALUE_W-1:0] rest;
         logic [3:0]                         dec[DEC_SLOTS];
         int                                 ndig;
         int                                 pad_n;
         int                                 len;
         int                                 count;
         int                                 pos;
         char_beat_type                      beat;
         rest = value;
         case (width_mode)
            bdascii_pkg::MODE_16: rest = value & 64'h0000_0000_0000_FFFF;
            bdascii_pkg::MODE_32: rest = value & 64'h0000_0000_FFFF_FFFF;
            default:              rest = value;
         endcase
         // Decimal digits, least significant first.
         for (int i = 0; i < DEC_SLOTS; i++) begin
            dec[i] = 4'(rest % 10);
            rest = rest / 10;
         end
         ndig = 1;
         for (int i = 1; i < DEC_SLOTS; i++) begin
            if (dec[i] != 0) begin
               ndig = i + 1;
            end
         end
         pad_n = (pad > bdascii_pkg::MAX_DIGITS_DEF) ? bdascii_pkg::MAX_DIGITS_DEF : int'(pad);
         len = (ndig > pad_n) ? ndig : pad_n;
         if (lim == 0) begin
            count = 0;
         end else if (lim != bdascii_pkg::NO_LIMIT && lim < len) begin
            count = lim;
         end else begin
            count = len;
         end
         // Characters go out most significant first; padding positions hold zero.
         for (int k = 0; k < count; k++) begin
            pos = len - 1 - k;
            beat.digit = bdascii_pkg::ASCII_ZERO + dec[pos];
            beat.last = (k + 1 == count);
            beat.remaining = (lim == bdascii_pkg::NO_LIMIT) ? bdascii_pkg::NO_LIMIT
                                                           : bdascii_pkg::LIMIT_W'(lim - (k + 1));
            expected_chars.push_back(beat);
         end
         requests_noted++;
      endfunction

      // Compares one accepted response beat with the oldest expected character.
      function void check_beat(logic [bdascii_pkg::CHAR_W-1:0] digit, logic last,
                               logic [bdascii_pkg::LIMIT_W-1:0] remaining);
         char_beat_type want;
         chars_checked++;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character beat: digit 0x%0h last %0b remaining %0d",
                     $time, digit, last, remaining);
            mismatches++;
            return;
         end
         want = expected_chars.pop_front();
         if (digit !== want.digit) begin
            $display("%0t: digit_char mismatch: expected 0x%0h, actual 0x%0h",
                     $time, want.digit, digit);
            mismatches++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
            mismatches++;
         end
         if (remaining !== want.remaining) begin
            $display("%0t: remaining_limit mismatch: expected %0d, actual %0d",
                     $time, want.remaining, remaining);
            mismatches++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_wr_en = 1'b0;
   logic [bdascii_pkg::MODE_W-1:0]     csr_wr_data = bdascii_pkg::MODE_RESET;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [bdascii_pkg::IN_VALUE_W-1:0] req_value = '0;
   logic [bdascii_pkg::LIMIT_W-1:0]    req_char_limit = '0;
   logic [bdascii_pkg::PAD_W-1:0]      req_pad_width = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [bdascii_pkg::CHAR_W-1:0]     rsp_digit_char;
   logic                               rsp_last;
   logic [bdascii_pkg::LIMIT_W-1:0]    rsp_remaining_limit;

   int                                 cycle_count = 0;
   rsp_style_type                      rsp_style = RSP_ALWAYS;
   DigitScoreboard                     sb = new();

   binary_to_decimal_ascii dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_value           (req_value),
      .req_char_limit      (req_char_limit),
      .req_pad_width       (req_pad_width),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_digit_char      (rsp_digit_char),
      .rsp_last            (rsp_last),
      .rsp_remaining_limit (rsp_remaining_limit)
   );

   always #CLOCK_HALF clock = ~clock;

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("binary_to_decimal_ascii regression: fail");
         $finish;
      end
   end

   // Response side: check each accepted beat, then choose the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_beat(rsp_digit_char, rsp_last, rsp_remaining_limit);
      end
      case (rsp_style)
         RSP_RANDOM:   rsp_ready <= ($urandom_range(0, 2) != 0);
         RSP_PERIODIC: rsp_ready <= ((cycle_count % 11) >= 4);
         default:      rsp_ready <= 1'b1;
      endcase
   end

   // Presents one request beat and holds it until the converter takes it.
   task automatic send_request(input logic [bdascii_pkg::IN_VALUE_W-1:0] value,
                               input logic [bdascii_pkg::LIMIT_W-1:0] lim,
                               input logic [bdascii_pkg::PAD_W-1:0] pad);
      req_valid <= 1'b1;
      req_value <= value;
      req_char_limit <= lim;
      req_pad_width <= pad;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sb.note_request(value, lim, pad);
   endtask

   // Drops valid for a number of cycles with a scrambled payload.
   task automatic pause_requests(input int cycles);
      req_valid <= 1'b0;
      req_value <= {$urandom, $urandom};
      repeat (cycles) @(posedge clock);
   endtask

   // Changes the width mode once every outstanding conversion has drained.
   task automatic write_width_mode(input logic [bdascii_pkg::MODE_W-1:0] mode);
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_width_mode(mode);
   endtask

   // Value classes: full range, small numbers, near powers of ten, random bit lengths.
   function automatic logic [bdascii_pkg::IN_VALUE_W-1:0] pick_value();
      logic [bdascii_pkg::IN_VALUE_W-1:0] tens;
      int                                 exponent;
      tens = 64'd1;
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return bdascii_pkg::IN_VALUE_W'($urandom_range(0, 99999));
         2: begin
            exponent = $urandom_range(0, 19);
            repeat (exponent) tens = tens * 10;
            return tens + $urandom_range(0, 2) - 1;
         end
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   // Limits: mostly unlimited or short, sometimes zero or anything.
   function automatic logic [bdascii_pkg::LIMIT_W-1:0] pick_limit();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         return bdascii_pkg::NO_LIMIT;
      end else if (sel < 8) begin
         return bdascii_pkg::LIMIT_W'($urandom_range(1, 22));
      end else if (sel == 8) begin
         return '0;
      end
      return bdascii_pkg::LIMIT_W'($urandom_range(0, 255));
   endfunction

   // Random requests in bursts with gaps; the response stall style changes per burst.
   // Valid is left high after the final beat; the caller drops it.
   task automatic send_random_requests(input int total);
      int burst_left;
      int gap;
      burst_left = 0;
      for (int i = 0; i < total; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            rsp_style <= rsp_style_type'($urandom_range(0, 2));
            if (gap != 0) begin
               pause_requests(gap);
            end
         end
         send_request(pick_value(), pick_limit(),
                      bdascii_pkg::PAD_W'($urandom_range(0, 31)));
         burst_left--;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests in the reset width mode, responses never stalled.
      send_request(64'd0, bdascii_pkg::NO_LIMIT, 5'd0);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, bdascii_pkg::NO_LIMIT, 5'd0);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 5'd0);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 5'd0);
      send_request(64'd12345, 8'd3, 5'd0);
      send_request(64'd7, bdascii_pkg::NO_LIMIT, 5'd20);
      send_request(64'd7, bdascii_pkg::NO_LIMIT, 5'd31);
      send_request(64'd0, 8'd254, 5'd31);
      send_request(64'd10000000000000000000, bdascii_pkg::NO_LIMIT, 5'd5);
      send_request(64'd9999999999999999999, bdascii_pkg::NO_LIMIT, 5'd0);
      send_request(64'd0, 8'd0, 5'd20);
      send_request(64'h5555_5555_5555_5555, 8'hAA, 5'd21);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 5'd10);
      send_request(64'd1, bdascii_pkg::NO_LIMIT, 5'd1);
      send_request(64'd123, 8'd2, 5'd10);
      send_request(64'd1000, bdascii_pkg::NO_LIMIT, 5'd3);

      // 16-bit mode: the upper bits must be dropped.
      write_width_mode(bdascii_pkg::MODE_16);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, bdascii_pkg::NO_LIMIT, 5'd0);
      send_request(64'h0000_0012_3450_0000, bdascii_pkg::NO_LIMIT, 5'd0);
      send_request(64'h0000_0000_0000_FFFF, 8'd3, 5'd31);
      send_random_requests(45);

      // 32-bit mode.
      write_width_mode(bdascii_pkg::MODE_32);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, bdascii_pkg::NO_LIMIT, 5'd0);
      send_request(64'h0000_0001_0000_0000, bdascii_pkg::NO_LIMIT, 5'd2);
      send_random_requests(45);

      // The unused code behaves as the full 64-bit width.
      write_width_mode(MODE_UNUSED);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, bdascii_pkg::NO_LIMIT, 5'd0);
      send_random_requests(35);

      // Back to the full width for a final run of random traffic.
      write_width_mode(bdascii_pkg::MODE_64);
      send_random_requests(63);
      req_valid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d conversions and %0d character beats over the 16, 32, 64-bit",
               sb.requests_noted, sb.chars_checked);
      $display("and unused width codes, with zero, short and unlimited character limits.");
      if (sb.mismatches == 0) begin
         $display("binary_to_decimal_ascii regression: pass");
      end else begin
         $display("binary_to_decimal_ascii regression: fail");
      end
      $finish;
   end

endmodule
